FILE: src/stam_pkg.sv
// ----------------------------------------------------------------------------
// stam_pkg: shared definitions for the sparse triplet add-merge core
// Field widths of the request and result channels, request codes and the
// default parameter values of the core.
// ----------------------------------------------------------------------------
package stam_pkg;

  localparam int ReqW    = 2;
  localparam int CoordW  = 10;
  localparam int ValueW  = 32;
  localparam int SumW    = 33;
  localparam int TotalW  = 7;

  localparam int DefDepth     = 32;
  localparam int DefCoordBits = 10;

  // Request codes.
  localparam logic [ReqW-1:0] REQ_LOAD_FIRST  = 2'd0;
  localparam logic [ReqW-1:0] REQ_LOAD_SECOND = 2'd1;
  localparam logic [ReqW-1:0] REQ_START       = 2'd2;

endpackage

FILE: src/stam_req_if.sv
// ----------------------------------------------------------------------------
// stam_req_if: request channel of the sparse triplet add-merge core
// Valid/ready channel that carries one load or start request.
// ----------------------------------------------------------------------------
interface stam_req_if;
  logic                          valid;
  logic                          ready;
  logic [stam_pkg::ReqW-1:0]     req_type;
  logic [stam_pkg::CoordW-1:0]   row;
  logic [stam_pkg::CoordW-1:0]   col;
  logic signed [stam_pkg::ValueW-1:0] value;

  modport source (output valid, output req_type, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input req_type, input row, input col, input value,
                  output ready);
endinterface

FILE: src/stam_res_if.sv
// ----------------------------------------------------------------------------
// stam_res_if: result channel of the sparse triplet add-merge core
// Valid/ready channel that carries one merged triplet.
// ----------------------------------------------------------------------------
interface stam_res_if;
  logic                               valid;
  logic                               ready;
  logic [stam_pkg::CoordW-1:0]        out_row;
  logic [stam_pkg::CoordW-1:0]        out_col;
  logic signed [stam_pkg::SumW-1:0]   sum;
  logic                               last;
  logic [stam_pkg::TotalW-1:0]        total_count;
  logic                               overflow;
  logic                               no_entry;

  modport source (output valid, output out_row, output out_col, output sum, output last,
                  output total_count, output overflow, output no_entry, input ready);
  modport sink   (input valid, input out_row, input out_col, input sum, input last,
                  input total_count, input overflow, input no_entry, output ready);
endinterface

FILE: src/sparse_triplet_add_merge_core.sv
// ----------------------------------------------------------------------------
// sparse_triplet_add_merge_core: merges and adds two sparse triplet lists
// Two on-chip stores hold (row, col, value) triplets; a start request runs a
// two-pointer merge with one shared compare and add unit.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries loads into the first or second list and a
//   start request. A load produces no result; a load into a full list is
//   dropped and raises the overflow flag of the next run. Request code 3 is
//   taken and ignored.
//   A start request runs the merge. For each merged triplet a read state
//   fetches the heads of both stores (registered memory read port), then an
//   emit state compares them, adds them in the shared adder and loads the
//   result register once it is free. The request channel is not ready until
//   the last result has been loaded. An empty run gives one result with
//   no_entry set.
//   The final result carries last and total_count; after it both lists and
//   the overflow flag are cleared.
//   When the receiver stalls, the result register holds its triplet and the
//   merge waits; loads are still taken once the run is over.
//   Reset (synchronous, active high) empties both lists, clears the flag and
//   the valid bit of the result register. Store contents are not cleared.
// ----------------------------------------------------------------------------
module sparse_triplet_add_merge_core #(
  parameter int DEPTH      = stam_pkg::DefDepth,
  parameter int COORD_BITS = stam_pkg::DefCoordBits
) (
  input  logic        clk,
  input  logic        rst,
  stam_req_if.sink    request,
  stam_res_if.source  result
);

  localparam int IdxW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW   = $clog2(DEPTH + 1);
  localparam int KW     = $clog2(2 * DEPTH + 1);
  localparam int KeyW   = 2 * COORD_BITS;
  localparam int EntryW = KeyW + stam_pkg::ValueW;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  logic [1:0] state;

  // Triplet stores: entry is {row, col, value}.
  logic [EntryW-1:0] first_store  [DEPTH];
  logic [EntryW-1:0] second_store [DEPTH];
  logic [EntryW-1:0] rd_a;
  logic [EntryW-1:0] rd_b;

  logic [CntW-1:0] first_count;
  logic [CntW-1:0] second_count;
  logic            dropped_flag;

  // Merge pointers and result count.
  logic [CntW-1:0] i_ptr;
  logic [CntW-1:0] j_ptr;
  logic [KW-1:0]   k_cnt;

  // Result register.
  logic                             res_valid;
  logic [stam_pkg::CoordW-1:0]      res_row;
  logic [stam_pkg::CoordW-1:0]      res_col;
  logic signed [stam_pkg::SumW-1:0] res_sum;
  logic                             res_last;
  logic [stam_pkg::TotalW-1:0]      res_total;
  logic                             res_overflow;
  logic                             res_no_entry;

  logic [EntryW-1:0] load_entry;
  logic              req_fire;
  logic              res_free;
  logic              res_load;

  assign request.ready = (state == ST_IDLE);
  assign req_fire      = request.valid && request.ready;
  assign res_free      = !res_valid || result.ready;
  // The result register takes a new triplet in either emitting state when it is free.
  assign res_load      = res_free && (state == ST_EMIT || state == ST_EMPTY);

  assign load_entry = {COORD_BITS'(request.row), COORD_BITS'(request.col), request.value};

  // Store write ports and registered read ports at the merge pointers.
  always_ff @(posedge clk) begin
    if (req_fire && request.req_type == stam_pkg::REQ_LOAD_FIRST && first_count < CntW'(DEPTH))
    begin
      first_store[first_count[IdxW-1:0]] <= load_entry;
    end
    if (req_fire && request.req_type == stam_pkg::REQ_LOAD_SECOND &&
        second_count < CntW'(DEPTH)) begin
      second_store[second_count[IdxW-1:0]] <= load_entry;
    end
    rd_a <= first_store[i_ptr[IdxW-1:0]];
    rd_b <= second_store[j_ptr[IdxW-1:0]];
  end

  // Shared compare and add unit working on the two fetched heads.
  logic [KeyW-1:0]                  key_a;
  logic [KeyW-1:0]                  key_b;
  logic                             a_ok;
  logic                             b_ok;
  logic                             use_a;
  logic                             use_b;
  logic signed [stam_pkg::SumW-1:0] opnd_a;
  logic signed [stam_pkg::SumW-1:0] opnd_b;
  logic signed [stam_pkg::SumW-1:0] add_out;
  logic [KeyW-1:0]                  key_sel;
  logic [CntW-1:0]                  i_next;
  logic [CntW-1:0]                  j_next;
  logic [KW-1:0]                    k_next;
  logic                             run_done;

  always_comb begin
    key_a = rd_a[EntryW-1 -: KeyW];
    key_b = rd_b[EntryW-1 -: KeyW];
    a_ok  = i_ptr < first_count;
    b_ok  = j_ptr < second_count;
    // A head is consumed when it is the smaller key, when both keys match, or when the other list is exhausted.
    use_a = a_ok && (!b_ok || key_a <= key_b);
    use_b = b_ok && (!a_ok || key_b <= key_a);
    opnd_a  = use_a ? stam_pkg::SumW'($signed(rd_a[stam_pkg::ValueW-1:0])) : '0;
    opnd_b  = use_b ? stam_pkg::SumW'($signed(rd_b[stam_pkg::ValueW-1:0])) : '0;
    add_out = opnd_a + opnd_b;
    key_sel = use_a ? key_a : key_b;
    i_next  = use_a ? i_ptr + CntW'(1) : i_ptr;
    j_next  = use_b ? j_ptr + CntW'(1) : j_ptr;
    k_next  = k_cnt + KW'(1);
    run_done = (i_next >= first_count) && (j_next >= second_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      first_count  <= '0;
      second_count <= '0;
      dropped_flag <= 1'b0;
      i_ptr        <= '0;
      j_ptr        <= '0;
      k_cnt        <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            case (request.req_type)
              stam_pkg::REQ_LOAD_FIRST: begin
                if (first_count < CntW'(DEPTH)) begin
                  first_count <= first_count + CntW'(1);
                end else begin
                  dropped_flag <= 1'b1;
                end
              end
              stam_pkg::REQ_LOAD_SECOND: begin
                if (second_count < CntW'(DEPTH)) begin
                  second_count <= second_count + CntW'(1);
                end else begin
                  dropped_flag <= 1'b1;
                end
              end
              stam_pkg::REQ_START: begin
                i_ptr <= '0;
                j_ptr <= '0;
                k_cnt <= '0;
                if (first_count == '0 && second_count == '0) begin
                  state <= ST_EMPTY;
                end else begin
                  state <= ST_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          // Heads at the new pointers are read into the registered read ports here.
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (res_free) begin
            res_row      <= stam_pkg::CoordW'(key_sel[KeyW-1 -: COORD_BITS]);
            res_col      <= stam_pkg::CoordW'(key_sel[COORD_BITS-1:0]);
            res_sum      <= add_out;
            res_overflow <= dropped_flag;
            res_no_entry <= 1'b0;
            i_ptr        <= i_next;
            j_ptr        <= j_next;
            k_cnt        <= k_next;
            if (run_done) begin
              res_last     <= 1'b1;
              res_total    <= stam_pkg::TotalW'(k_next);
              first_count  <= '0;
              second_count <= '0;
              dropped_flag <= 1'b0;
              state        <= ST_IDLE;
            end else begin
              res_last  <= 1'b0;
              res_total <= '0;
              state     <= ST_READ;
            end
          end
        end
        ST_EMPTY: begin
          if (res_free) begin
            res_row      <= '0;
            res_col      <= '0;
            res_sum      <= '0;
            res_last     <= 1'b1;
            res_total    <= '0;
            res_overflow <= dropped_flag;
            res_no_entry <= 1'b1;
            dropped_flag <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign result.valid       = res_valid;
  assign result.out_row     = res_row;
  assign result.out_col     = res_col;
  assign result.sum         = res_sum;
  assign result.last        = res_last;
  assign result.total_count = res_total;
  assign result.overflow    = res_overflow;
  assign result.no_entry    = res_no_entry;

endmodule
